// ===== design/iets_pkg.sv =====
// Shared types and constants for the I2C EEPROM transaction sequencer.
`default_nettype none

package iets_pkg;

   // Input item kinds, carried on tuser.
   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_DATA  = 2'd2,
      CMD_DONE  = 2'd3
   } cmd_type;

   // Bus primitives.
   typedef enum logic [2:0] {
      OP_NONE    = 3'd0,
      OP_START   = 3'd1,
      OP_RESTART = 3'd2,
      OP_SEND    = 3'd3,
      OP_RECV    = 3'd4,
      OP_ACK     = 3'd5,
      OP_NACK    = 3'd6,
      OP_STOP    = 3'd7
   } bus_op_type;

   // Transfer status.
   typedef enum logic [2:0] {
      ST_BUSY     = 3'd0,
      ST_DONE     = 3'd1,
      ST_ABSENT   = 3'd2,
      ST_NACK     = 3'd3,
      ST_REJECTED = 3'd4
   } status_type;

   // Configuration register indexes.
   localparam logic CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic CSR_RETRY_LIMIT    = 1'b1;

   localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'h50;
   localparam logic [7:0] RETRY_LIMIT_RESET    = 8'd10;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 32;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] word_address;
      logic [7:0] byte_count;
      logic [7:0] data_byte;
      logic       ack_failed;
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      bus_op_type bus_op;
      logic       wait_ms;
      logic [7:0] bus_byte;
      logic [7:0] read_data;
      logic       read_valid;
      logic       data_request;
      status_type status;
   } rsp_item_type;

   // Handshake between the stages.
   typedef struct packed {
      logic advance;   // item moves from input register to result register
      logic out_free;  // result register can take an item this cycle
   } flow_type;

endpackage

`default_nettype wire

// ===== design/iets_in_stage.sv =====
// Input register stage of the sequencer.
`default_nettype none

module iets_in_stage (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        in_valid,
   output logic                       in_ready,
   input  wire iets_pkg::req_item_type in_item,
   input  wire iets_pkg::flow_type    flow,
   output logic                       item_valid,
   output iets_pkg::req_item_type     item
);
   import iets_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   assign in_ready   = !valid_ff || flow.advance;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (flow.advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

`default_nettype wire

// ===== design/iets_step.sv =====
// Transaction state machine: one input item in, one result item (bus primitive or status) out.
`default_nettype none

module iets_step (
   input  wire                        clock,
   input  wire                        reset,
   input  wire iets_pkg::flow_type    flow,
   input  wire iets_pkg::req_item_type item,
   input  wire [6:0]                  device_address,
   input  wire [7:0]                  retry_limit,
   output iets_pkg::rsp_item_type     result
);
   import iets_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE        = 4'd0,
      PH_START       = 4'd1,
      PH_ADDR_W      = 4'd2,
      PH_WORD        = 4'd3,
      PH_RESTART     = 4'd4,
      PH_ADDR_R      = 4'd5,
      PH_DATA_REQ    = 4'd6,
      PH_DATA_W      = 4'd7,
      PH_RECV        = 4'd8,
      PH_ACKED       = 4'd9,
      PH_STOP_DONE   = 4'd10,
      PH_STOP_ABSENT = 4'd11,
      PH_STOP_NACK   = 4'd12
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic       is_read_ff, is_read_in;
   logic [7:0] word_addr_ff, word_addr_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [7:0] retry_ff, retry_in;

   always_comb begin
      phase_in      = phase_ff;
      is_read_in    = is_read_ff;
      word_addr_in  = word_addr_ff;
      bytes_left_in = bytes_left_ff;
      retry_in      = retry_ff;
      result        = '0;

      unique case (item.cmd) inside
         CMD_WRITE, CMD_READ: begin
            if (phase_ff == PH_IDLE) begin
               is_read_in    = (item.cmd == CMD_READ);
               word_addr_in  = item.word_address;
               // a read of zero bytes reads one
               bytes_left_in = (item.cmd == CMD_READ && item.byte_count == 8'd0) ?
                               8'd1 : item.byte_count;
               retry_in      = 8'd0;
               result.bus_op = OP_START;
               phase_in      = PH_START;
            end else begin
               result.status = ST_REJECTED;
            end
         end
         CMD_DATA: begin
            if (phase_ff == PH_DATA_REQ) begin
               result.bus_op   = OP_SEND;
               result.bus_byte = item.data_byte;
               bytes_left_in   = bytes_left_ff - 8'd1;
               phase_in        = PH_DATA_W;
            end
         end
         CMD_DONE: begin
            unique case (phase_ff)
               PH_START: begin
                  result.bus_op   = OP_SEND;
                  result.bus_byte = {device_address, 1'b0};
                  phase_in        = PH_ADDR_W;
               end
               PH_ADDR_W: begin
                  if (item.ack_failed) begin
                     if (retry_ff >= retry_limit) begin
                        result.bus_op = OP_STOP;
                        phase_in      = PH_STOP_ABSENT;
                     end else begin
                        // device busy with its write cycle: wait and poll again
                        retry_in       = retry_ff + 8'd1;
                        result.bus_op  = OP_START;
                        result.wait_ms = 1'b1;
                        phase_in       = PH_START;
                     end
                  end else begin
                     result.bus_op   = OP_SEND;
                     result.bus_byte = word_addr_ff;
                     phase_in        = PH_WORD;
                  end
               end
               PH_WORD, PH_DATA_W: begin
                  if (item.ack_failed) begin
                     result.bus_op = OP_STOP;
                     phase_in      = PH_STOP_NACK;
                  end else if (is_read_ff && phase_ff == PH_WORD) begin
                     result.bus_op = OP_RESTART;
                     phase_in      = PH_RESTART;
                  end else if (bytes_left_ff == 8'd0) begin
                     result.bus_op = OP_STOP;
                     phase_in      = PH_STOP_DONE;
                  end else begin
                     result.data_request = 1'b1;
                     phase_in            = PH_DATA_REQ;
                  end
               end
               PH_RESTART: begin
                  result.bus_op   = OP_SEND;
                  result.bus_byte = {device_address, 1'b1};
                  phase_in        = PH_ADDR_R;
               end
               PH_ADDR_R: begin
                  if (item.ack_failed) begin
                     result.bus_op = OP_STOP;
                     phase_in      = PH_STOP_NACK;
                  end else begin
                     result.bus_op = OP_RECV;
                     phase_in      = PH_RECV;
                  end
               end
               PH_RECV: begin
                  result.read_data  = item.rx_byte;
                  result.read_valid = 1'b1;
                  bytes_left_in     = bytes_left_ff - 8'd1;
                  // last byte gets a nack
                  result.bus_op     = (bytes_left_ff == 8'd1) ? OP_NACK : OP_ACK;
                  phase_in          = PH_ACKED;
               end
               PH_ACKED: begin
                  if (bytes_left_ff == 8'd0) begin
                     result.bus_op = OP_STOP;
                     phase_in      = PH_STOP_DONE;
                  end else begin
                     result.bus_op = OP_RECV;
                     phase_in      = PH_RECV;
                  end
               end
               PH_STOP_DONE: begin
                  result.status = ST_DONE;
                  phase_in      = PH_IDLE;
               end
               PH_STOP_ABSENT: begin
                  result.status = ST_ABSENT;
                  phase_in      = PH_IDLE;
               end
               PH_STOP_NACK: begin
                  result.status = ST_NACK;
                  phase_in      = PH_IDLE;
               end
               default: begin
                  // idle or awaiting data: completion ignored
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         is_read_ff    <= 1'b0;
         word_addr_ff  <= 8'd0;
         bytes_left_ff <= 8'd0;
         retry_ff      <= 8'd0;
      end else if (flow.advance) begin
         phase_ff      <= phase_in;
         is_read_ff    <= is_read_in;
         word_addr_ff  <= word_addr_in;
         bytes_left_ff <= bytes_left_in;
         retry_ff      <= retry_in;
      end
   end

   // A request accepted while idle always opens with a start.
   a_req_starts: assert property (@(posedge clock) disable iff (reset)
      (flow.advance && phase_ff == PH_IDLE &&
       (item.cmd == CMD_WRITE || item.cmd == CMD_READ)) |=> phase_ff == PH_START)
      else $error("request from idle did not enter start phase");

   // A received byte is always handed out with its ack or nack.
   a_read_with_ack: assert property (@(posedge clock) disable iff (reset)
      (flow.advance && result.read_valid) |->
      (result.bus_op == OP_ACK || result.bus_op == OP_NACK))
      else $error("read byte without ack/nack");

   // The retry counter never runs past the limit.
   a_retry_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_START && retry_ff != 8'd0) |-> retry_ff <= retry_limit)
      else $error("retry count beyond limit");

   // Final status only comes back to idle.
   a_status_idle: assert property (@(posedge clock) disable iff (reset)
      (flow.advance && (result.status == ST_DONE || result.status == ST_ABSENT ||
                        result.status == ST_NACK)) |=> phase_ff == PH_IDLE)
      else $error("final status without return to idle");

endmodule

`default_nettype wire

// ===== design/iets_out_stage.sv =====
// Result register stage of the sequencer.
`default_nettype none

module iets_out_stage (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        item_valid,
   input  wire iets_pkg::rsp_item_type result,
   output iets_pkg::flow_type         flow,
   output logic                       out_valid,
   input  wire                        out_ready,
   output iets_pkg::rsp_item_type     out_item
);
   import iets_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   assign flow.out_free = !valid_ff || out_ready;
   assign flow.advance  = item_valid && flow.out_free;
   assign out_valid     = valid_ff;
   assign out_item      = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (flow.advance) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (flow.advance) begin
         item_ff <= result;
      end
   end

endmodule

`default_nettype wire

// ===== design/i2c_eeprom_transaction_sequencer.sv =====
// Top level: I2C EEPROM transaction sequencer with config registers and stream ports.
// Path: an accepted input item is held in the input register, and its result item is
//   registered in the result register, which drives rsp.
// Throughput: one item per cycle while rsp_tready is high; an empty input register takes
//   an item while a result waits, and the result register frees when rsp_tready is high.
// Reset (synchronous, active high): both stages empty, sequencer idle,
//   device_address = 0x50, retry_limit = 10.
`default_nettype none

module i2c_eeprom_transaction_sequencer (
   input  wire         clock,
   input  wire         reset,
   // request stream
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [1:0]  req_tuser,   // cmd
   // word_address[7:0], byte_count[15:8], data_byte[23:16], ack_failed[24],
   // rx_byte[32:25], zero[39:33]
   input  wire  [iets_pkg::REQ_DATA_W-1:0] req_tdata,
   // result stream
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // bus_op[2:0], wait_ms[3], bus_byte[11:4], read_data[19:12], read_valid[20],
   // data_request[21], status[24:22], zero[31:25]
   output logic [iets_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // config write port
   input  wire         csr_we,
   input  wire         csr_index,
   input  wire  [7:0]  csr_wdata
);
   import iets_pkg::*;

   logic [6:0]   dev_addr_ff;
   logic [7:0]   retry_limit_ff;
   req_item_type req_item, cur_item;
   rsp_item_type result, out_item;
   flow_type     flow;
   logic         cur_valid;

   // Config registers; the user must write them only while the sequencer is idle, the block does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff    <= DEVICE_ADDRESS_RESET;
         retry_limit_ff <= RETRY_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEVICE_ADDRESS: dev_addr_ff    <= csr_wdata[6:0];
            CSR_RETRY_LIMIT:    retry_limit_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Unpack request item.
   always_comb begin
      req_item.cmd          = cmd_type'(req_tuser);
      req_item.word_address = req_tdata[7:0];
      req_item.byte_count   = req_tdata[15:8];
      req_item.data_byte    = req_tdata[23:16];
      req_item.ack_failed   = req_tdata[24];
      req_item.rx_byte      = req_tdata[32:25];
   end

   iets_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .flow       (flow),
      .item_valid (cur_valid),
      .item       (cur_item)
   );

   // Sequencer state only moves when an item advances into the result register.
   iets_step u_step (
      .clock          (clock),
      .reset          (reset),
      .flow           (flow),
      .item           (cur_item),
      .device_address (dev_addr_ff),
      .retry_limit    (retry_limit_ff),
      .result         (result)
   );

   iets_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .item_valid (cur_valid),
      .result     (result),
      .flow       (flow),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_item   (out_item)
   );

   // Pack result item, first field lowest.
   assign rsp_tdata = {7'd0, out_item.status, out_item.data_request, out_item.read_valid,
                       out_item.read_data, out_item.bus_byte, out_item.wait_ms,
                       out_item.bus_op};

endmodule

`default_nettype wire
